// ===== src/swc_pkg.sv =====
// Shared types, constants and character helpers of the serial weekday clock.
package swc_pkg;

   localparam logic [7:0]  CMD_QUERY   = 8'd49;
   localparam logic [7:0]  CMD_LOAD    = 8'd2;
   localparam logic [15:0] TPS_RESET   = 16'd312;
   localparam logic [7:0]  SEC_LIMIT   = 8'd60;
   localparam logic [7:0]  MIN_LIMIT   = 8'd60;
   localparam logic [7:0]  HOUR_LIMIT  = 8'd24;
   localparam logic [7:0]  DAY_WRAP    = 8'd7;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_COLON  = 8'h3a;
   localparam logic        TYPE_TICK   = 1'b0;

   // byte positions within the eleven-byte reply "DDDhh:mm:ss"
   localparam logic [3:0]  POS_DAY0    = 4'd0;
   localparam logic [3:0]  POS_DAY1    = 4'd1;
   localparam logic [3:0]  POS_DAY2    = 4'd2;
   localparam logic [3:0]  POS_HOUR_T  = 4'd3;
   localparam logic [3:0]  POS_HOUR_U  = 4'd4;
   localparam logic [3:0]  POS_COLON_A = 4'd5;
   localparam logic [3:0]  POS_MIN_T   = 4'd6;
   localparam logic [3:0]  POS_MIN_U   = 4'd7;
   localparam logic [3:0]  POS_COLON_B = 4'd8;
   localparam logic [3:0]  POS_SEC_T   = 4'd9;
   localparam logic [3:0]  POS_SEC_U   = 4'd10;

   typedef enum logic [2:0] {
      LOAD_IDLE = 3'd0,
      LOAD_DAY  = 3'd1,
      LOAD_HOUR = 3'd2,
      LOAD_MIN  = 3'd3,
      LOAD_SEC  = 3'd4
   } swc_load_type;

   typedef struct packed {
      logic [7:0] weekday;
      logic [7:0] hours;
      logic [7:0] minutes;
      logic [7:0] seconds;
   } swc_snap_type;

   localparam logic [23:0] DAY_NAMES [8] = '{
      "Lun", "Mar", "Mer", "Gio", "Ven", "Sab", "Dom", "---"
   };

   function automatic logic [7:0] day_char(input logic [7:0] day, input logic [1:0] pos);
      logic [2:0]  sel;
      logic [23:0] name;
      logic [7:0]  ch;
      sel  = (day < DAY_WRAP) ? day[2:0] : 3'd7;
      name = DAY_NAMES[sel];
      unique case (pos)
         2'd0:    ch = name[23:16];
         2'd1:    ch = name[15:8];
         default: ch = name[7:0];
      endcase
      return ch;
   endfunction

endpackage

// ===== src/swc_front.sv =====
// Front end: takes request words, keeps the clock state and queues time snapshots.
module swc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output swc_pkg::swc_snap_type q_push_data
);
   import swc_pkg::*;

   logic [15:0]  tps_ff, tps_in;
   logic [15:0]  tick_ff, tick_in;
   logic [7:0]   sec_ff, sec_in;
   logic [7:0]   min_ff, min_in;
   logic [7:0]   hour_ff, hour_in;
   logic [7:0]   day_ff, day_in;
   swc_load_type load_ff, load_in;
   logic         accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign q_push_data.weekday = day_ff;
   assign q_push_data.hours   = hour_ff;
   assign q_push_data.minutes = min_ff;
   assign q_push_data.seconds = sec_ff;

   always_comb begin
      tps_in  = csr_wr_en ? csr_wr_data : tps_ff;
      tick_in = tick_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      day_in  = day_ff;
      load_in = load_ff;
      q_push  = 1'b0;
      if (accept) begin
         if (req_type == TYPE_TICK) begin
            // ripple the carry from prescaler up to weekday
            tick_in = tick_ff + 16'd1;
            if (tick_in == tps_ff) begin
               tick_in = '0;
               sec_in  = sec_ff + 8'd1;
               if (sec_in >= SEC_LIMIT) begin
                  sec_in = '0;
                  min_in = min_ff + 8'd1;
                  if (min_in >= MIN_LIMIT) begin
                     min_in  = '0;
                     hour_in = hour_ff + 8'd1;
                     if (hour_in >= HOUR_LIMIT) begin
                        hour_in = '0;
                        day_in  = day_ff + 8'd1;
                        if (day_in == DAY_WRAP) begin
                           day_in = '0;
                        end
                     end
                  end
               end
            end
         end else begin
            unique case (load_ff)
               LOAD_DAY: begin
                  day_in  = req_rx_byte;
                  load_in = LOAD_HOUR;
               end
               LOAD_HOUR: begin
                  hour_in = req_rx_byte;
                  load_in = LOAD_MIN;
               end
               LOAD_MIN: begin
                  min_in  = req_rx_byte;
                  load_in = LOAD_SEC;
               end
               LOAD_SEC: begin
                  sec_in  = req_rx_byte;
                  tick_in = '0;
                  load_in = LOAD_IDLE;
               end
               default: begin
                  load_in = LOAD_IDLE;
                  if (req_rx_byte == CMD_QUERY) begin
                     q_push = 1'b1;
                  end else if (req_rx_byte == CMD_LOAD) begin
                     load_in = LOAD_DAY;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff  <= TPS_RESET;
         tick_ff <= '0;
         sec_ff  <= '0;
         min_ff  <= '0;
         hour_ff <= '0;
         day_ff  <= '0;
         load_ff <= LOAD_IDLE;
      end else begin
         tps_ff  <= tps_in;
         tick_ff <= tick_in;
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
         day_ff  <= day_in;
         load_ff <= load_in;
      end
   end

endmodule

// ===== src/swc_queue.sv =====
// Small FIFO of time snapshots between front end and reply serializer.
module swc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  swc_pkg::swc_snap_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output swc_pkg::swc_snap_type head
);
   import swc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   swc_snap_type  slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/swc_back.sv =====
// Back end: turns one queued snapshot into the eleven ASCII reply words.
module swc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  swc_pkg::swc_snap_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_last
);
   import swc_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        advance;
   logic        tens_sel;
   logic [7:0]  value;
   logic [15:0] prod;
   logic [4:0]  quot;
   logic [4:0]  tens;
   logic [7:0]  units;
   logic [7:0]  digit_char;

   assign advance     = q_not_empty && (!valid_ff || rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_last    = last_ff;

   // pick the field for this position; value / 10 is (value * 205) >> 11 below 1029
   always_comb begin
      unique case (pos_ff)
         POS_HOUR_T, POS_HOUR_U: value = q_head.hours;
         POS_MIN_T, POS_MIN_U:   value = q_head.minutes;
         default:                value = q_head.seconds;
      endcase
      tens_sel = (pos_ff == POS_HOUR_T) || (pos_ff == POS_MIN_T) || (pos_ff == POS_SEC_T);
      prod     = {8'd0, value} * 16'd205;
      quot     = prod[15:11];
      if (quot >= 5'd20) begin
         tens = quot - 5'd20;
      end else if (quot >= 5'd10) begin
         tens = quot - 5'd10;
      end else begin
         tens = quot;
      end
      units      = value - {quot, 3'd0} - {2'd0, quot, 1'b0};
      digit_char = tens_sel ? (CHAR_ZERO + {3'd0, tens}) : (CHAR_ZERO + units);
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (advance) begin
         valid_in = 1'b1;
         last_in  = (pos_ff == POS_SEC_U);
         unique case (pos_ff)
            POS_DAY0:                 byte_in = day_char(q_head.weekday, 2'd0);
            POS_DAY1:                 byte_in = day_char(q_head.weekday, 2'd1);
            POS_DAY2:                 byte_in = day_char(q_head.weekday, 2'd2);
            POS_COLON_A, POS_COLON_B: byte_in = CHAR_COLON;
            default:                  byte_in = digit_char;
         endcase
         if (pos_ff == POS_SEC_U) begin
            // drop the snapshot with its final word
            pos_in = POS_DAY0;
            q_pop  = 1'b1;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_DAY0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

// ===== src/serial_weekday_clock_unit.sv =====
// Top level of the serial weekday clock: front end, snapshot queue and reply serializer.
// Every request word (tick or received byte) is taken back to back, as long as the
// snapshot queue has room; ticks and load bytes update the registered clock state.
// A query byte (49) stores a snapshot of day, hour, minute and second, and the serializer
// sends it as eleven words "DDDhh:mm:ss", one per cycle while rsp_ready is high. The
// reply being sent keeps its queue slot until its final word, so QUEUE_DEPTH - 1 replies
// can wait behind it; only when the queue is full does req_ready drop. ticks_per_second
// is written through csr_wr_en.
module serial_weekday_clock_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last
);
   import swc_pkg::*;

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_not_empty;
   swc_snap_type q_push_data;
   swc_snap_type q_head;

   swc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   swc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   swc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== src/swc_checker.sv =====
// Port-level checks of the serial weekday clock, bound to the top level.
module swc_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last
);
   import swc_pkg::*;

   // a stalled reply word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("reply word changed while stalled");

   // no reply right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   // the final word of a reply is a seconds digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_tx_byte >= CHAR_ZERO && rsp_tx_byte <= 8'h39)
      else $error("final reply word is not a digit");

endmodule

bind serial_weekday_clock_unit swc_port_checks u_swc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_tx_byte (rsp_tx_byte),
   .rsp_last    (rsp_last)
);
